// ===== rtl/hcfr_pkg.sv =====
// Package for the haptic contact force renderer.
// Holds mode codes, register indexes, fixed widths and reset values.
// No dependencies.
package hcfr_pkg;

   // Object selection codes held in the mode register.
   localparam logic [2:0] MODE_NONE    = 3'd0;
   localparam logic [2:0] MODE_FLOOR   = 3'd1;
   localparam logic [2:0] MODE_BOX     = 3'd2;
   localparam logic [2:0] MODE_SPH_IN  = 3'd3;
   localparam logic [2:0] MODE_SPH_OUT = 3'd4;

   // Configuration register indexes.
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] REG_MODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STIFF   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FLOOR   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SIDE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SPHERE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CURSOR  = 3'd5;

   // Fixed field widths.
   localparam int unsigned MODE_W  = 3;
   localparam int unsigned STIFF_W = 16;
   localparam int unsigned LEN_W   = 15;
   localparam int unsigned RAD_W   = 16;
   localparam int unsigned QUOT_W  = 17;
   localparam int unsigned FORCE_W = 24;
   localparam logic [FORCE_W-1:0] FORCE_MAX = 24'h7FFFFF;

   // Register reset values.
   localparam logic [MODE_W-1:0]  RST_MODE   = MODE_NONE;
   localparam logic [STIFF_W-1:0] RST_STIFF  = 16'd128;
   localparam logic [15:0]        RST_FLOOR  = 16'hFD80;
   localparam logic [LEN_W-1:0]   RST_SIDE   = 15'd6400;
   localparam logic [LEN_W-1:0]   RST_SPHERE = 15'd1920;
   localparam logic [LEN_W-1:0]   RST_CURSOR = 15'd320;

endpackage

// ===== rtl/hcfr_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Carries a valid bit and an opaque sideband word alongside the data.
// No package dependencies.
module hcfr_sqrt #(
   parameter int SW  = 34,
   parameter int SBW = 8
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  logic [SW-1:0]  in_rad,
   input  logic [SBW-1:0] in_sb,
   output logic           out_valid,
   output logic [SW/2-1:0] out_root,
   output logic [SBW-1:0] out_sb
);
   localparam int RW  = SW / 2;
   localparam int RMW = RW + 2;

   logic [SW-1:0]  rad_ff  [RW];
   logic [RMW-1:0] rem_ff  [RW];
   logic [RW-1:0]  root_ff [RW];
   logic [SBW-1:0] sb_ff   [RW];
   logic [RW-1:0]  v_ff;

   logic [SW-1:0]  rad_in  [RW];
   logic [RMW-1:0] rem_in  [RW];
   logic [RW-1:0]  root_in [RW];

   // Each stage brings down two radicand bits and decides one root bit.
   always_comb begin
      logic [SW-1:0]  src_rad;
      logic [RMW-1:0] src_rem;
      logic [RW-1:0]  src_root;
      logic [RMW-1:0] rem_sh;
      logic [RMW-1:0] trial;
      logic           ge;
      for (int j = 0; j < RW; j++) begin
         if (j == 0) begin
            src_rad  = in_rad;
            src_rem  = '0;
            src_root = '0;
         end else begin
            src_rad  = rad_ff[j-1];
            src_rem  = rem_ff[j-1];
            src_root = root_ff[j-1];
         end
         rem_sh     = {src_rem[RMW-3:0], src_rad[SW-1:SW-2]};
         trial      = {src_root, 2'b01};
         ge         = (rem_sh >= trial);
         rem_in[j]  = ge ? (rem_sh - trial) : rem_sh;
         root_in[j] = {src_root[RW-2:0], ge};
         rad_in[j]  = src_rad << 2;
      end
   end

   // Stage registers advance together under the pipeline enable.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[RW-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < RW; j++) begin
            rad_ff[j]  <= rad_in[j];
            rem_ff[j]  <= rem_in[j];
            root_ff[j] <= root_in[j];
            sb_ff[j]   <= (j == 0) ? in_sb : sb_ff[(j == 0) ? 0 : j-1];
         end
      end
   end

   assign out_valid = v_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_sb    = sb_ff[RW-1];

endmodule

// ===== rtl/hcfr_div.sv =====
// Pipelined restoring divider for three lanes that share one divisor.
// Rounds to nearest by adding half the divisor in its first stage.
// No package dependencies.
module hcfr_div #(
   parameter int NMW  = 32,
   parameter int DENW = 17,
   parameter int QW   = 17,
   parameter int SBW  = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [2:0][NMW-1:0]  in_num,
   input  logic [DENW-1:0]      in_den,
   input  logic [SBW-1:0]       in_sb,
   output logic                 out_valid,
   output logic [2:0][QW-1:0]   out_quot,
   output logic [SBW-1:0]       out_sb
);
   localparam int NW = ((NMW + 1) > (DENW + QW - 1)) ? (NMW + 1) : (DENW + QW - 1);
   localparam int NS = QW + 1;

   logic [2:0][NW-1:0] num_ff  [NS];
   logic [2:0][QW-1:0] quot_ff [NS];
   logic [DENW-1:0]    den_ff  [NS];
   logic [SBW-1:0]     sb_ff   [NS];
   logic [NS-1:0]      v_ff;

   logic [2:0][NW-1:0] num_in  [NS];
   logic [2:0][QW-1:0] quot_in [NS];

   // Stage zero adds the rounding term; later stages each settle one quotient bit.
   always_comb begin
      logic [NW-1:0] dsh;
      logic          ge;
      for (int l = 0; l < 3; l++) begin
         num_in[0][l]  = NW'(in_num[l]) + NW'(in_den >> 1);
         quot_in[0][l] = '0;
      end
      for (int j = 1; j < NS; j++) begin
         dsh = NW'(den_ff[j-1]) << (QW - j);
         for (int l = 0; l < 3; l++) begin
            ge            = (num_ff[j-1][l] >= dsh);
            num_in[j][l]  = ge ? (num_ff[j-1][l] - dsh) : num_ff[j-1][l];
            quot_in[j][l] = {quot_ff[j-1][l][QW-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < NS; j++) begin
            num_ff[j]  <= num_in[j];
            quot_ff[j] <= quot_in[j];
            den_ff[j]  <= (j == 0) ? in_den : den_ff[(j == 0) ? 0 : j-1];
            sb_ff[j]   <= (j == 0) ? in_sb : sb_ff[(j == 0) ? 0 : j-1];
         end
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_quot  = quot_ff[NS-1];
   assign out_sb    = sb_ff[NS-1];

endmodule

// ===== rtl/hcfr_force.sv =====
// Spring force stages: stiffness times displacement, then round and saturate.
// Depends on hcfr_pkg for the force width and limit.
module hcfr_force #(
   parameter int DW  = 19,
   parameter int SBW = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  logic [2:0][DW-1:0]                    in_diff,
   input  logic [hcfr_pkg::STIFF_W-1:0]          stiff,
   input  logic [SBW-1:0]                        in_sb,
   output logic                                  out_valid,
   output logic [2:0][hcfr_pkg::FORCE_W-1:0]     out_force,
   output logic [SBW-1:0]                        out_sb
);
   localparam int PRW = DW + hcfr_pkg::STIFF_W;
   localparam int FW  = hcfr_pkg::FORCE_W;

   logic [2:0][PRW-1:0] prod_ff;
   logic [2:0]          neg_ff;
   logic [SBW-1:0]      sba_ff;
   logic                va_ff;
   logic [2:0][FW-1:0]  force_ff;
   logic [SBW-1:0]      sbb_ff;
   logic                vb_ff;

   logic [2:0][PRW-1:0] prod_in;
   logic [2:0]          neg_in;
   logic [2:0][FW-1:0]  force_in;

   // Magnitude of the displacement times stiffness.
   always_comb begin
      logic [DW-1:0] mag;
      for (int l = 0; l < 3; l++) begin
         neg_in[l]  = in_diff[l][DW-1];
         mag        = neg_in[l] ? (DW'(0) - in_diff[l]) : in_diff[l];
         prod_in[l] = PRW'(mag) * PRW'(stiff);
      end
   end

   // Divide by sixteen with rounding, clip to the force range, restore the sign.
   always_comb begin
      logic [PRW:0]  rnd;
      logic [FW-1:0] mag_f;
      for (int l = 0; l < 3; l++) begin
         rnd   = ((PRW+1)'(prod_ff[l]) + (PRW+1)'(8)) >> 4;
         mag_f = (rnd > (PRW+1)'(hcfr_pkg::FORCE_MAX)) ? hcfr_pkg::FORCE_MAX : rnd[FW-1:0];
         force_in[l] = neg_ff[l] ? (FW'(0) - mag_f) : mag_f;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_in;
         neg_ff   <= neg_in;
         sba_ff   <= in_sb;
         force_ff <= force_in;
         sbb_ff   <= sba_ff;
      end
   end

   assign out_valid = vb_ff;
   assign out_force = force_ff;
   assign out_sb    = sbb_ff;

endmodule

// ===== rtl/haptic_contact_force_render_top.sv =====
// Haptic contact force renderer, top level.
// Depends on hcfr_pkg, hcfr_sqrt, hcfr_div and hcfr_force.
//
// Usage: each item on the req_ channel is one cursor position (x, y, z) in
// 1/64 mm. Each item yields exactly one rsp_ item: a penalty spring force per
// axis in 1/1024 N, the proxy point on the selected surface and a contact
// flag. The csr_ channel writes the six configuration registers by index
// (mode, stiffness, floor height, box side, sphere radius, cursor radius);
// csr_ready is always high; registers are to be written only while idle, which
// the block itself does not enforce. Throughput: one item per cycle while the
// pipeline is not frozen. Items pass the square root stages (one per root
// bit) and the divider's rounding stage and stages (one per quotient bit).
// Stalls: when rsp_stall holds back a result, it moves into an output skid
// register as the pipeline advances; then the whole pipeline freezes and
// req_stall rises until the skid register drains. No item is lost or repeated.
// Reset: synchronous, active high; clears all valid bits and the skid flag
// and restores the register defaults. There is no clearing pass.
module haptic_contact_force_render_top #(
   parameter int POSITION_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [POSITION_WIDTH-1:0]       req_pos_x,
   input  logic signed [POSITION_WIDTH-1:0]       req_pos_y,
   input  logic signed [POSITION_WIDTH-1:0]       req_pos_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [hcfr_pkg::FORCE_W-1:0]    rsp_force_x,
   output logic signed [hcfr_pkg::FORCE_W-1:0]    rsp_force_y,
   output logic signed [hcfr_pkg::FORCE_W-1:0]    rsp_force_z,
   output logic signed [POSITION_WIDTH-1:0]       rsp_proxy_x,
   output logic signed [POSITION_WIDTH-1:0]       rsp_proxy_y,
   output logic signed [POSITION_WIDTH-1:0]       rsp_proxy_z,
   output logic                                   rsp_in_contact,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [hcfr_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [hcfr_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   localparam int PW   = POSITION_WIDTH;
   localparam int SW   = 2 * PW + 2;
   localparam int RW   = SW / 2;
   localparam int QW   = hcfr_pkg::QUOT_W;
   localparam int RADW = hcfr_pkg::RAD_W;
   localparam int NMW  = RADW + PW;
   localparam int QVW  = ((PW > QW) ? PW : QW) + 1;
   localparam int DW   = QVW + 1;
   localparam int CMPW = (SW > 2 * RADW) ? SW : 2 * RADW;
   localparam int FW   = hcfr_pkg::FORCE_W;

   typedef struct packed {
      logic [2:0][PW-1:0]  p;
      logic [2:0][QVW-1:0] preq;
      logic                hit;
      logic                usediv;
   } mid_type;

   typedef struct packed {
      mid_type             mid;
      logic [2:0][NMW-1:0] nm;
   } sq_sb_type;

   typedef struct packed {
      logic [2:0][PW-1:0]  proxy;
      logic                hit;
   } out_sb_type;

   // Configuration registers.
   logic [hcfr_pkg::MODE_W-1:0]  mode_ff;
   logic [hcfr_pkg::STIFF_W-1:0] stiff_ff;
   logic signed [15:0]           floor_ff;
   logic [hcfr_pkg::LEN_W-1:0]   side_ff;
   logic [hcfr_pkg::LEN_W-1:0]   sphere_ff;
   logic [hcfr_pkg::LEN_W-1:0]   cursor_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= hcfr_pkg::RST_MODE;
         stiff_ff  <= hcfr_pkg::RST_STIFF;
         floor_ff  <= signed'(hcfr_pkg::RST_FLOOR);
         side_ff   <= hcfr_pkg::RST_SIDE;
         sphere_ff <= hcfr_pkg::RST_SPHERE;
         cursor_ff <= hcfr_pkg::RST_CURSOR;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            hcfr_pkg::REG_MODE:   mode_ff   <= csr_wdata[hcfr_pkg::MODE_W-1:0];
            hcfr_pkg::REG_STIFF:  stiff_ff  <= csr_wdata;
            hcfr_pkg::REG_FLOOR:  floor_ff  <= signed'(csr_wdata);
            hcfr_pkg::REG_SIDE:   side_ff   <= csr_wdata[hcfr_pkg::LEN_W-1:0];
            hcfr_pkg::REG_SPHERE: sphere_ff <= csr_wdata[hcfr_pkg::LEN_W-1:0];
            hcfr_pkg::REG_CURSOR: cursor_ff <= csr_wdata[hcfr_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline enable: everything moves unless the skid register is full.
   logic skid_full_ff;
   logic en;
   assign en        = !skid_full_ff;
   assign req_stall = skid_full_ff;

   // Stage 1: capture the position.
   logic                 v1_ff;
   logic signed [PW-1:0] p1_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff[0] <= req_pos_x;
         p1_ff[1] <= req_pos_y;
         p1_ff[2] <= req_pos_z;
      end
   end

   // Stage 2: squares, wall proxies for floor and box, sphere radius.
   logic                 v2_ff;
   logic signed [PW-1:0] p2_ff [3];
   logic [2*PW-1:0]      sq2_ff [3];
   logic [2:0][QVW-1:0]  preq2_ff;
   logic                 hitw2_ff;
   logic [RADW-1:0]      rad2_ff;
   logic                 sph_in2_ff;
   logic                 sph_out2_ff;

   logic [2*PW-1:0]      sq2_in [3];
   logic [2:0][QVW-1:0]  preq2_in;
   logic                 hitw2_in;
   logic [RADW-1:0]      rad2_in;
   logic                 sph_in2_in;
   logic                 sph_out2_in;

   always_comb begin
      logic signed [2*PW-1:0] sqs;
      logic signed [16:0]     cr;
      logic signed [16:0]     surf;
      logic signed [16:0]     bound;
      logic signed [QVW-1:0]  pe;
      logic signed [QVW-1:0]  ae;
      logic signed [QVW-1:0]  be;
      logic signed [QVW-1:0]  se;
      cr    = signed'({2'b00, cursor_ff});
      surf  = 17'(floor_ff) + cr;
      bound = signed'({3'b000, side_ff[hcfr_pkg::LEN_W-1:1]}) - cr;
      be    = QVW'(bound);
      se    = QVW'(surf);
      hitw2_in    = 1'b0;
      rad2_in     = '0;
      sph_in2_in  = 1'b0;
      sph_out2_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         sqs       = p1_ff[i] * p1_ff[i];
         sq2_in[i] = unsigned'(sqs);
         pe        = QVW'(p1_ff[i]);
         ae        = (p1_ff[i] < 0) ? -pe : pe;
         preq2_in[i] = pe;
         unique case (mode_ff)
            hcfr_pkg::MODE_FLOOR: begin
               if (i == 1 && pe < se) begin
                  preq2_in[i] = se;
                  hitw2_in    = 1'b1;
               end
            end
            hcfr_pkg::MODE_BOX: begin
               if (ae > be) begin
                  preq2_in[i] = (p1_ff[i] > 0) ? be : -be;
                  hitw2_in    = 1'b1;
               end
            end
            default: ;
         endcase
      end
      unique case (mode_ff)
         hcfr_pkg::MODE_SPH_IN: begin
            sph_in2_in = 1'b1;
            rad2_in    = (sphere_ff >= cursor_ff) ? RADW'(sphere_ff - cursor_ff) : '0;
         end
         hcfr_pkg::MODE_SPH_OUT: begin
            sph_out2_in = 1'b1;
            rad2_in     = RADW'(sphere_ff) + RADW'(cursor_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p2_ff       <= p1_ff;
         sq2_ff      <= sq2_in;
         preq2_ff    <= preq2_in;
         hitw2_ff    <= hitw2_in;
         rad2_ff     <= rad2_in;
         sph_in2_ff  <= sph_in2_in;
         sph_out2_ff <= sph_out2_in;
      end
   end

   // Stage 3: squared distance, squared radius, radius times |p| per axis.
   logic                 v3_ff;
   logic signed [PW-1:0] p3_ff [3];
   logic [SW-1:0]        s3_ff;
   logic [2*RADW-1:0]    rsq3_ff;
   logic [2:0][NMW-1:0]  nm3_ff;
   logic [2:0][QVW-1:0]  preq3_ff;
   logic                 hitw3_ff;
   logic                 sph_in3_ff;
   logic                 sph_out3_ff;

   logic [2:0][NMW-1:0]  nm3_in;

   always_comb begin
      logic [PW-1:0] ap;
      for (int i = 0; i < 3; i++) begin
         ap        = p2_ff[i][PW-1] ? (PW'(0) - unsigned'(p2_ff[i])) : unsigned'(p2_ff[i]);
         nm3_in[i] = NMW'(rad2_ff) * NMW'(ap);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p3_ff       <= p2_ff;
         s3_ff       <= SW'(sq2_ff[0]) + SW'(sq2_ff[1]) + SW'(sq2_ff[2]);
         rsq3_ff     <= (2*RADW)'(rad2_ff) * (2*RADW)'(rad2_ff);
         nm3_ff      <= nm3_in;
         preq3_ff    <= preq2_ff;
         hitw3_ff    <= hitw2_ff;
         sph_in3_ff  <= sph_in2_ff;
         sph_out3_ff <= sph_out2_ff;
      end
   end

   // Stage 4: sphere contact test, then hand off to the square root.
   logic          v4_ff;
   logic [SW-1:0] s4_ff;
   sq_sb_type     sb4_ff;
   sq_sb_type     sb4_in;

   always_comb begin
      logic sph_hit;
      sph_hit = (sph_in3_ff  && (CMPW'(s3_ff) > CMPW'(rsq3_ff))) ||
                (sph_out3_ff && (CMPW'(s3_ff) < CMPW'(rsq3_ff)));
      for (int i = 0; i < 3; i++) begin
         sb4_in.mid.p[i] = unsigned'(p3_ff[i]);
      end
      sb4_in.mid.preq   = preq3_ff;
      sb4_in.mid.hit    = hitw3_ff || sph_hit;
      sb4_in.mid.usediv = sph_hit && (s3_ff != '0);
      sb4_in.nm         = nm3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_ff  <= s3_ff;
         sb4_ff <= sb4_in;
      end
   end

   // Square root of the squared distance.
   logic          sq_v;
   logic [RW-1:0] sq_root;
   sq_sb_type     sq_sb;

   hcfr_sqrt #(
      .SW  (SW),
      .SBW ($bits(sq_sb_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v4_ff),
      .in_rad    (s4_ff),
      .in_sb     (sb4_ff),
      .out_valid (sq_v),
      .out_root  (sq_root),
      .out_sb    (sq_sb)
   );

   // Scale the position onto the sphere surface: R * |p| / r per axis.
   logic               dv_v;
   logic [2:0][QW-1:0] dv_quot;
   mid_type            dv_sb;

   hcfr_div #(
      .NMW  (NMW),
      .DENW (RW),
      .QW   (QW),
      .SBW  ($bits(mid_type))
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_v),
      .in_num    (sq_sb.nm),
      .in_den    (sq_root),
      .in_sb     (sq_sb.mid),
      .out_valid (dv_v),
      .out_quot  (dv_quot),
      .out_sb    (dv_sb)
   );

   // Select stage: final proxy, displacement and saturated proxy output.
   logic                vs_ff;
   logic [2:0][DW-1:0]  diff_ff;
   out_sb_type          osb_ff;
   logic [2:0][DW-1:0]  diff_in;
   out_sb_type          osb_in;

   always_comb begin
      logic signed [QVW-1:0] qv;
      logic signed [QVW-1:0] qd;
      logic signed [QVW-1:0] pe;
      logic signed [QVW-1:0] pmax;
      logic signed [QVW-1:0] pmin;
      pmax = QVW'(signed'({1'b0, {(PW-1){1'b1}}}));
      pmin = QVW'(signed'({1'b1, {(PW-1){1'b0}}}));
      for (int i = 0; i < 3; i++) begin
         pe = QVW'(signed'(dv_sb.p[i]));
         qd = signed'(QVW'(dv_quot[i]));
         if (dv_sb.usediv) begin
            qv = dv_sb.p[i][PW-1] ? -qd : qd;
         end else begin
            qv = signed'(dv_sb.preq[i]);
         end
         diff_in[i] = unsigned'(DW'(qv) - DW'(pe));
         if (qv > pmax) begin
            osb_in.proxy[i] = unsigned'(pmax[PW-1:0]);
         end else if (qv < pmin) begin
            osb_in.proxy[i] = unsigned'(pmin[PW-1:0]);
         end else begin
            osb_in.proxy[i] = unsigned'(qv[PW-1:0]);
         end
      end
      osb_in.hit = dv_sb.hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vs_ff <= 1'b0;
      end else if (en) begin
         vs_ff <= dv_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff <= diff_in;
         osb_ff  <= osb_in;
      end
   end

   // Spring force per axis.
   logic               f_v;
   logic [2:0][FW-1:0] f_force;
   out_sb_type         f_sb;

   hcfr_force #(
      .DW  (DW),
      .SBW ($bits(out_sb_type))
   ) u_force (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vs_ff),
      .in_diff   (diff_ff),
      .stiff     (stiff_ff),
      .in_sb     (osb_ff),
      .out_valid (f_v),
      .out_force (f_force),
      .out_sb    (f_sb)
   );

   // Output skid register: holds one result while the receiver stalls.
   logic [2:0][FW-1:0] skid_force_ff;
   out_sb_type         skid_sb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff <= 1'b0;
      end else if (!skid_full_ff && f_v && rsp_stall) begin
         skid_full_ff <= 1'b1;
      end else if (skid_full_ff && !rsp_stall) begin
         skid_full_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_full_ff) begin
         skid_force_ff <= f_force;
         skid_sb_ff    <= f_sb;
      end
   end

   // Result channel.
   logic [2:0][FW-1:0] o_force;
   out_sb_type         o_sb;

   assign rsp_valid      = skid_full_ff || f_v;
   assign o_force        = skid_full_ff ? skid_force_ff : f_force;
   assign o_sb           = skid_full_ff ? skid_sb_ff : f_sb;
   assign rsp_force_x    = signed'(o_force[0]);
   assign rsp_force_y    = signed'(o_force[1]);
   assign rsp_force_z    = signed'(o_force[2]);
   assign rsp_proxy_x    = signed'(o_sb.proxy[0]);
   assign rsp_proxy_y    = signed'(o_sb.proxy[1]);
   assign rsp_proxy_z    = signed'(o_sb.proxy[2]);
   assign rsp_in_contact = o_sb.hit;

endmodule

// ===== rtl/hcfr_checker.sv =====
// Port-level checks for the haptic contact force renderer.
// Depends on hcfr_pkg; bound to haptic_contact_force_render_top below.
module hcfr_port_checks (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [hcfr_pkg::FORCE_W-1:0]        rsp_force_x,
   input logic [hcfr_pkg::FORCE_W-1:0]        rsp_force_y,
   input logic [hcfr_pkg::FORCE_W-1:0]        rsp_force_z,
   input logic                                rsp_in_contact
);
   localparam logic [hcfr_pkg::FORCE_W-1:0] FORCE_MIN = ~hcfr_pkg::FORCE_MAX;

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // Without contact every axis carries zero force.
   a_no_contact: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_contact |->
         rsp_force_x == '0 && rsp_force_y == '0 && rsp_force_z == '0)
      else $error("force without contact");

   // Saturation is symmetric, so the most negative code never appears.
   a_sym_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_force_x != FORCE_MIN && rsp_force_y != FORCE_MIN && rsp_force_z != FORCE_MIN)
      else $error("force outside symmetric range");

   // Reset empties the pipeline and releases the input.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

endmodule

bind haptic_contact_force_render_top hcfr_port_checks u_hcfr_port_checks (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_force_x    (rsp_force_x),
   .rsp_force_y    (rsp_force_y),
   .rsp_force_z    (rsp_force_z),
   .rsp_in_contact (rsp_in_contact)
);
